>>> src/gbb_pkg.sv
package gbb_pkg;

    // Field and register widths fixed by the block's interface.
    localparam int DIM_W      = 12;
    localparam int COORD_W    = 11;
    localparam int PIX_W      = 8;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register index, taken from paddr[2].
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Reset values of the frame size registers.
    localparam logic [DIM_W-1:0] RESET_IMAGE_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RESET_IMAGE_HEIGHT = 12'd480;

    // Luma weights in 0.8 fixed point. They sum to 256.
    localparam logic [7:0] LUMA_R     = 8'd54;
    localparam logic [7:0] LUMA_G     = 8'd184;
    localparam logic [7:0] LUMA_B     = 8'd18;
    localparam int         LUMA_SHIFT = 8;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             restart;
    } t_cfg;

    typedef struct packed {
        logic tap_load;
        logic sum_load;
        logic out_load;
    } t_win_ctl;

endpackage

>>> src/gbb_apb_regs.sv
module gbb_apb_regs #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int KERNEL_SIZE = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbb_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gbb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output gbb_pkg::t_cfg                   o_cfg
);
    import gbb_pkg::*;

    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;
    logic             w_wr;
    logic             w_idx;

    // Values below the kernel or above the storage limit are saturated.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        logic [DIM_W-1:0] res;
        if (32'(v) < 32'(KERNEL_SIZE)) begin
            res = DIM_W'(KERNEL_SIZE);
        end else if (32'(v) > 32'(hi)) begin
            res = DIM_W'(hi);
        end else begin
            res = v;
        end
        return res;
    endfunction

    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_IMAGE_WIDTH;
            r_height <= RESET_IMAGE_HEIGHT;
        end else if (w_wr) begin
            case (w_idx)
                REG_IMAGE_WIDTH:  r_width  <= clamp_dim(pwdata[DIM_W-1:0], MAX_WIDTH);
                REG_IMAGE_HEIGHT: r_height <= clamp_dim(pwdata[DIM_W-1:0], MAX_HEIGHT);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(r_width);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(r_height);
            default:          prdata = '0;
        endcase
    end

    // Every write hits one of the two registers and restarts the frame.
    always_comb begin
        o_cfg.width   = r_width;
        o_cfg.height  = r_height;
        o_cfg.restart = w_wr;
    end

endmodule

>>> src/gbb_line_mem.sv
module gbb_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 48
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DATA_W-1:0]        o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DATA_W-1:0]        i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Successive pixels of a row use different columns, so a read meets the
    // write-back of the same column in one cycle only after a restart.
    a_no_same_addr: assert property (@(posedge i_clk)
        (i_rd_en && i_wr_en) |-> (i_rd_addr != i_wr_addr))
        else $error("line store read and write hit the same column");

endmodule

>>> src/gbb_window.sv
module gbb_window #(
    parameter int KERNEL_SIZE = 7
) (
    input  logic                          i_clk,
    input  gbb_pkg::t_win_ctl             i_ctl,
    input  logic [(KERNEL_SIZE-1)*8-1:0]  i_line,
    input  logic [gbb_pkg::PIX_W-1:0]     i_gray,
    input  logic                          i_win_valid,
    output logic [gbb_pkg::PIX_W-1:0]     o_blurred
);
    import gbb_pkg::*;

    localparam int KK        = KERNEL_SIZE * KERNEL_SIZE;
    localparam int LINE_W    = (KERNEL_SIZE - 1) * 8;
    localparam int COL_W     = KERNEL_SIZE * 8;
    localparam int CSUM_W    = $clog2(KERNEL_SIZE * 255 + 1);
    localparam int WSUM_W    = $clog2(KK * 255 + 1);
    localparam int DIV_SHIFT = WSUM_W + 6;
    localparam int RECIP     = ((1 << DIV_SHIFT) + KK - 1) / KK;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int PROD_W    = WSUM_W + RECIP_W;

    logic [COL_W-1:0]  w_col;
    logic [CSUM_W-1:0] n_csum;
    logic [WSUM_W-1:0] n_wsum;
    logic [PROD_W-1:0] n_prod;
    logic [CSUM_W-1:0] r_tap [KERNEL_SIZE];
    logic [WSUM_W-1:0] r_wsum;

    assign w_col = {i_line[LINE_W-1:0], i_gray};

    always_comb begin
        n_csum = '0;
        for (int i = 0; i < KERNEL_SIZE; i++) begin
            n_csum = n_csum + CSUM_W'(w_col[8*i +: 8]);
        end
    end

    always_comb begin
        n_wsum = '0;
        for (int j = 0; j < KERNEL_SIZE; j++) begin
            n_wsum = n_wsum + WSUM_W'(r_tap[j]);
        end
    end

    // Division by the window area as a multiply by a rounded-up reciprocal;
    // the shift leaves enough guard bits to make the floor exact.
    assign n_prod = PROD_W'(r_wsum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ctl.tap_load) begin
            r_tap[0] <= n_csum;
            for (int j = 1; j < KERNEL_SIZE; j++) begin
                r_tap[j] <= r_tap[j-1];
            end
        end
        if (i_ctl.sum_load) begin
            r_wsum <= n_wsum;
        end
        if (i_ctl.out_load) begin
            o_blurred <= i_win_valid ? n_prod[DIV_SHIFT +: PIX_W] : '0;
        end
    end

endmodule

>>> src/gray_box_blur_7x7.sv
// Grayscale 7x7 box blur over a raster stream of BGR pixels. Each pixel is
// turned to gray with 0.8 fixed-point luma weights, and for every accepted
// pixel one word comes out: the floor of the window sum divided by the window
// area, for the center pixel half a kernel up and to the left of the incoming
// one, with its row and column. window_valid is low, and the blurred value
// zero, while the window still reaches past the top or left edge; the center
// coordinates read zero while the center itself lies outside the image. The
// block takes one pixel per clock unless stalled; a word passes stage
// registers s1 to s4. The line store sets the pace: a single-port-read
// memory of MAX_WIDTH entries holding the previous KERNEL_SIZE-1 rows of
// each column, read and written back once per pixel. Stalls on the output
// hold the whole pipeline and back up to the input ready. The line store
// needs no clearing pass after reset: an entry only contributes to a valid
// result after the current frame has rewritten it. Writing image_width or
// image_height over the APB port restarts the frame at row 0, column 0;
// values are saturated to the range from KERNEL_SIZE to MAX_WIDTH or
// MAX_HEIGHT. Registers sit at byte addresses 0 (width) and 4 (height).
module gray_box_blur_7x7 #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int KERNEL_SIZE = 7
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Pixel input.
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [gbb_pkg::PIX_W-1:0]       i_blue,
    input  logic [gbb_pkg::PIX_W-1:0]       i_green,
    input  logic [gbb_pkg::PIX_W-1:0]       i_red,
    // Result output.
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [gbb_pkg::PIX_W-1:0]       o_blurred_gray,
    output logic                            o_window_valid,
    output logic [gbb_pkg::COORD_W-1:0]     o_center_row,
    output logic [gbb_pkg::COORD_W-1:0]     o_center_col,
    // Configuration port.
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbb_pkg::PADDR_W-1:0]     paddr,
    input  logic [gbb_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gbb_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import gbb_pkg::*;

    localparam int LINE_W = (KERNEL_SIZE - 1) * 8;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HALF_D = DIM_W'(KERNEL_SIZE / 2);
    localparam logic [DIM_W-1:0] KM1_D  = DIM_W'(KERNEL_SIZE - 1);
    localparam logic [COORD_W-1:0] MIN_CENTER = COORD_W'(KERNEL_SIZE - 1 - KERNEL_SIZE / 2);

    t_cfg     w_cfg;
    t_win_ctl w_win_ctl;

    // Handshake and stage flow. A stage is free when it is empty or its word
    // moves on in this cycle.
    logic w_s1_free, w_s2_free, w_s3_free, w_s4_free;
    logic w_acc, w_ld2, w_ld3, w_ld4;

    // Position of the next pixel.
    logic [DIM_W-1:0] r_col, r_row;
    logic [DIM_W-1:0] n_col, n_row;

    // Stage registers: gray value and column address in the first stage,
    // result flags and center coordinates carried along to the output.
    logic               r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [PIX_W-1:0]   r_s1_gray;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_wv, r_s2_wv, r_s3_wv, r_s4_wv;
    logic [COORD_W-1:0] r_s1_crow, r_s2_crow, r_s3_crow, r_s4_crow;
    logic [COORD_W-1:0] r_s1_ccol, r_s2_ccol, r_s3_ccol, r_s4_ccol;

    logic [15:0]        n_gray_full;
    logic [PIX_W-1:0]   n_gray;
    logic               n_wv;
    logic               n_center_in;
    logic [COORD_W-1:0] n_crow, n_ccol;

    logic [LINE_W-1:0]  w_rd_line;
    logic [LINE_W-1:0]  n_line;

    gbb_apb_regs #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_s4_free = !r_s4_v || i_ready;
    assign w_s3_free = !r_s3_v || w_s4_free;
    assign w_s2_free = !r_s2_v || w_s3_free;
    assign w_s1_free = !r_s1_v || w_s2_free;
    assign w_ld4     = r_s3_v && w_s4_free;
    assign w_ld3     = r_s2_v && w_s3_free;
    assign w_ld2     = r_s1_v && w_s2_free;
    assign o_ready   = w_s1_free;
    assign w_acc     = i_valid && w_s1_free;

    // Gray conversion straight off the input port; weights sum to 256 so
    // the top byte of the 16-bit sum never overflows.
    assign n_gray_full = 16'(LUMA_R) * 16'(i_red) + 16'(LUMA_G) * 16'(i_green)
                       + 16'(LUMA_B) * 16'(i_blue);
    assign n_gray      = n_gray_full[LUMA_SHIFT +: PIX_W];

    // The window is full once the incoming pixel has KERNEL_SIZE-1 rows above
    // it and as many columns to its left.
    assign n_wv        = (r_row >= KM1_D) && (r_col >= KM1_D);
    assign n_center_in = (r_row >= HALF_D) && (r_col >= HALF_D);
    assign n_crow      = n_center_in ? COORD_W'(r_row - HALF_D) : '0;
    assign n_ccol      = n_center_in ? COORD_W'(r_col - HALF_D) : '0;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (w_cfg.restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_acc) begin
            if (r_col + 1'b1 >= w_cfg.width) begin
                n_col = '0;
                n_row = (r_row + 1'b1 >= w_cfg.height) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // The column's stored history is read when the pixel is accepted and
    // comes back while the word is in stage one; the history shifted down a
    // row, new gray on top, is written back as the word leaves stage one.
    assign n_line = {w_rd_line[LINE_W-PIX_W-1:0], r_s1_gray};

    gbb_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_acc),
        .i_rd_addr (ADDR_W'(r_col)),
        .o_rd_data (w_rd_line),
        .i_wr_en   (w_ld2),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (n_line)
    );

    always_comb begin
        w_win_ctl.tap_load = w_ld2;
        w_win_ctl.sum_load = w_ld3;
        w_win_ctl.out_load = w_ld4;
    end

    gbb_window #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_window (
        .i_clk       (i_clk),
        .i_ctl       (w_win_ctl),
        .i_line      (w_rd_line),
        .i_gray      (r_s1_gray),
        .i_win_valid (r_s3_wv),
        .o_blurred   (o_blurred_gray)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (w_s1_free) begin
                r_s1_v <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (w_s3_free) begin
                r_s3_v <= r_s2_v;
            end
            if (w_s4_free) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    // Payload of the stages.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_gray <= n_gray;
            r_s1_addr <= ADDR_W'(r_col);
            r_s1_wv   <= n_wv;
            r_s1_crow <= n_crow;
            r_s1_ccol <= n_ccol;
        end
        if (w_ld2) begin
            r_s2_wv   <= r_s1_wv;
            r_s2_crow <= r_s1_crow;
            r_s2_ccol <= r_s1_ccol;
        end
        if (w_ld3) begin
            r_s3_wv   <= r_s2_wv;
            r_s3_crow <= r_s2_crow;
            r_s3_ccol <= r_s2_ccol;
        end
        if (w_ld4) begin
            r_s4_wv   <= r_s3_wv;
            r_s4_crow <= r_s3_crow;
            r_s4_ccol <= r_s3_ccol;
        end
    end

    assign o_valid        = r_s4_v;
    assign o_window_valid = r_s4_wv;
    assign o_center_row   = r_s4_crow;
    assign o_center_col   = r_s4_ccol;

    // The pixel position always stays inside the configured frame.
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < w_cfg.width) && (r_row < w_cfg.height))
        else $error("pixel position left the configured frame");

    // A full window always has its center at least half a kernel inside.
    a_center_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_window_valid) |->
            ((o_center_row >= MIN_CENTER) && (o_center_col >= MIN_CENTER)))
        else $error("full window reported with its center on the border");

    // Border words carry a zero blurred value.
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_window_valid) |-> (o_blurred_gray == '0))
        else $error("border word carries a nonzero blurred value");

endmodule

>>> tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gbb_pkg::*;

    // Geometry of the filter as the block is built here.
    localparam int KSIZE          = 7;
    localparam int HALF_K         = KSIZE / 2;
    localparam int MAX_DIM        = 2048;
    // Stimulus sizing and pacing.
    localparam int RANDOM_ITEMS   = 1150;
    localparam int MAX_SIZE_ITEMS = 80;
    localparam int IDLE_PCT       = 27;
    localparam int CYCLE_LIMIT    = 600000;
    // Register byte addresses; the register index sits in paddr[2].
    localparam logic [PADDR_W-1:0] WIDTH_ADDR  = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [PADDR_W-1:0] HEIGHT_ADDR = {REG_IMAGE_HEIGHT, 2'b00};

    // One output word of the block, field by field.
    typedef struct packed {
        logic [PIX_W-1:0]   blurred_gray;
        logic               window_valid;
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
    } t_blur_word;

    // Every pixel of the first HALF_K rows of a frame yields this word: the window
    // is not full yet and the center pixel lies above the image.
    localparam t_blur_word BORDER_WORD = '0;

    // One row of the opening stimulus. When typed is set, want holds the word
    // that is read off directly; otherwise the word comes from blur_pixel.
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             typed;
        t_blur_word       want;
    } t_pixel_row;

    // Pixel content of one random frame phase.
    typedef enum int {
        TEXTURE_NOISE,
        TEXTURE_WHITE,
        TEXTURE_BINARY
    } t_texture;

    // Block ports. All inputs start at known values.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_valid        = 1'b0;
    logic                  o_ready;
    logic [PIX_W-1:0]      i_blue         = '0;
    logic [PIX_W-1:0]      i_green        = '0;
    logic [PIX_W-1:0]      i_red          = '0;
    logic                  o_valid;
    logic                  i_ready        = 1'b0;
    logic [PIX_W-1:0]      o_blurred_gray;
    logic                  o_window_valid;
    logic [COORD_W-1:0]    o_center_row;
    logic [COORD_W-1:0]    o_center_col;
    logic                  psel           = 1'b0;
    logic                  penable        = 1'b0;
    logic                  pwrite         = 1'b0;
    logic [PADDR_W-1:0]    paddr          = '0;
    logic [APB_DATA_W-1:0] pwdata         = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Our own image of the filter state: the column history of the last six
    // rows, the seven newest window columns, the raster position of the next
    // pixel and the frame size registers.
    logic [8*(KSIZE-1)-1:0] line_hist [MAX_DIM];
    logic [8*KSIZE-1:0]     win_cols [KSIZE];
    int unsigned            pos_col;
    int unsigned            pos_row;
    int unsigned            frame_w;
    int unsigned            frame_h;

    // Words still owed by the block, oldest first.
    t_blur_word  blur_words_due [$];
    int unsigned mismatch_count = 0;
    int unsigned pixels_sent    = 0;
    int unsigned cycle_count    = 0;
    // While calm is set, neither side inserts idle cycles.
    logic        calm           = 1'b0;

    gray_box_blur_7x7 dut (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_ready,
        .i_blue,
        .i_green,
        .i_red,
        .o_valid,
        .i_ready,
        .o_blurred_gray,
        .o_window_valid,
        .o_center_row,
        .o_center_col,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Works out the word that one pixel produces and advances the raster
    // position. The gray value is shifted into the column history, the new
    // column enters the window, and the window sum is divided by 49.
    function automatic t_blur_word blur_pixel(input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] r);
        int unsigned      c;
        int unsigned      rw;
        int unsigned      gray;
        int unsigned      acc;
        logic [8*KSIZE-1:0] column;
        t_blur_word       w;
        gray = (54 * r + 184 * g + 18 * b) >> 8;
        c = pos_col;
        rw = pos_row;
        column = {line_hist[c], gray[7:0]};
        line_hist[c] = column[8*(KSIZE-1)-1:0];
        for (int j = KSIZE - 1; j > 0; j--) begin
            win_cols[j] = win_cols[j-1];
        end
        win_cols[0] = column;
        acc = 0;
        for (int j = 0; j < KSIZE; j++) begin
            for (int i = 0; i < KSIZE; i++) begin
                acc += win_cols[j][8*i +: 8];
            end
        end
        w = BORDER_WORD;
        // The window is full only once six rows and six columns lie behind us.
        if (rw >= KSIZE - 1 && c >= KSIZE - 1) begin
            w.window_valid = 1'b1;
            w.blurred_gray = PIX_W'(acc / (KSIZE * KSIZE));
        end
        // The center coordinates stay zero while the center is off the image.
        if (rw >= HALF_K && c >= HALF_K) begin
            w.center_row = COORD_W'(rw - HALF_K);
            w.center_col = COORD_W'(c - HALF_K);
        end
        c++;
        if (c >= frame_w) begin
            c = 0;
            rw++;
            if (rw >= frame_h) begin
                rw = 0;
            end
        end
        pos_col = c;
        pos_row = rw;
        return w;
    endfunction

    // A register write keeps only the low twelve bits, saturates them to the
    // legal frame size, and restarts the frame at row 0, column 0.
    function automatic void set_dim(input logic [PADDR_W-1:0] addr,
                                    input logic [APB_DATA_W-1:0] data);
        int unsigned v;
        v = data[DIM_W-1:0];
        if (v < KSIZE) begin
            v = KSIZE;
        end
        if (v > MAX_DIM) begin
            v = MAX_DIM;
        end
        if (addr == WIDTH_ADDR) begin
            frame_w = v;
        end else begin
            frame_h = v;
        end
        pos_col = 0;
        pos_row = 0;
    endfunction

    // APB write: a setup phase, then an access phase that ends when pready is
    // high. An idle wait at the end keeps back-to-back calls apart.
    task automatic write_dim(input logic [PADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        set_dim(addr, data);
        @(posedge i_clk);
    endtask

    // APB read; prdata is taken at the edge that completes the access.
    task automatic read_dim(input logic [PADDR_W-1:0] addr, input int unsigned want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(want)) begin
            $error("prdata at address %0d: expected %0d, got %0d", addr, want, prdata);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offers one pixel and returns at the edge that accepts it. Valid is left
    // high so the next pixel can follow at once; an idle gap lowers it first.
    task automatic send_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r, input logic typed,
                              input t_blur_word want);
        t_blur_word w;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (!calm && $urandom_range(99) < IDLE_PCT);
        end
        i_valid <= 1'b1;
        i_blue  <= b;
        i_green <= g;
        i_red   <= r;
        w = blur_pixel(b, g, r);
        blur_words_due.push_back(typed ? want : w);
        do @(posedge i_clk); while (!o_ready);
        pixels_sent++;
    endtask

    // Lowers valid and waits until every owed word has come out.
    task automatic drain_words();
        i_valid <= 1'b0;
        while (blur_words_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The receiving side stalls at random, except during the calm stretch.
    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Each word taken from the block is compared with the oldest one owed.
    always @(posedge i_clk) begin
        t_blur_word due;
        if (i_rst_n && o_valid && i_ready) begin
            if (blur_words_due.size() == 0) begin
                $error("word with nothing owed: blurred_gray %0d, window_valid %0d",
                       o_blurred_gray, o_window_valid);
                mismatch_count++;
            end else begin
                due = blur_words_due.pop_front();
                if (o_blurred_gray !== due.blurred_gray) begin
                    $error("blurred_gray: expected %0d, got %0d",
                           due.blurred_gray, o_blurred_gray);
                    mismatch_count++;
                end
                if (o_window_valid !== due.window_valid) begin
                    $error("window_valid: expected %0d, got %0d",
                           due.window_valid, o_window_valid);
                    mismatch_count++;
                end
                if (o_center_row !== due.center_row) begin
                    $error("center_row: expected %0d, got %0d",
                           due.center_row, o_center_row);
                    mismatch_count++;
                end
                if (o_center_col !== due.center_col) begin
                    $error("center_col: expected %0d, got %0d",
                           due.center_col, o_center_col);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("gray_box_blur_7x7 regression: fail");
            $finish;
        end
    end

    initial begin
        t_pixel_row       opening_rows [14];
        t_texture         texture;
        int unsigned      phase;
        int unsigned      count;
        int unsigned      random_start;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;

        foreach (line_hist[k]) begin
            line_hist[k] = '0;
        end
        foreach (win_cols[k]) begin
            win_cols[k] = '0;
        end
        pos_col = 0;
        pos_row = 0;
        frame_w = 640;
        frame_h = 480;

        // The opening pixels all land in the first row of the reset-size
        // frame, so every one of them is a border pixel whose center lies
        // outside the image. They walk the channel extremes and bit patterns.
        opening_rows = '{
            '{8'd0,   8'd0,   8'd0,   1'b1, BORDER_WORD},
            '{8'd255, 8'd255, 8'd255, 1'b1, BORDER_WORD},
            '{8'd255, 8'd0,   8'd0,   1'b1, BORDER_WORD},
            '{8'd0,   8'd255, 8'd0,   1'b1, BORDER_WORD},
            '{8'd0,   8'd0,   8'd255, 1'b1, BORDER_WORD},
            '{8'd170, 8'd85,  8'd170, 1'b1, BORDER_WORD},
            '{8'd85,  8'd170, 8'd85,  1'b1, BORDER_WORD},
            '{8'd1,   8'd128, 8'd254, 1'b0, BORDER_WORD},
            '{8'd128, 8'd1,   8'd127, 1'b0, BORDER_WORD},
            '{8'd254, 8'd254, 8'd254, 1'b1, BORDER_WORD},
            '{8'd255, 8'd255, 8'd0,   1'b0, BORDER_WORD},
            '{8'd0,   8'd255, 8'd255, 1'b0, BORDER_WORD},
            '{8'd15,  8'd240, 8'd60,  1'b0, BORDER_WORD},
            '{8'd255, 8'd255, 8'd255, 1'b1, BORDER_WORD}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Frame size registers come out of reset at 640 by 480.
        read_dim(WIDTH_ADDR, 640);
        read_dim(HEIGHT_ADDR, 480);

        foreach (opening_rows[k]) begin
            send_pixel(opening_rows[k].blue, opening_rows[k].green, opening_rows[k].red,
                       opening_rows[k].typed, opening_rows[k].want);
        end
        drain_words();

        // Saturation of out-of-range sizes; only the low twelve bits count.
        write_dim(WIDTH_ADDR, 32'h0000_0000);
        read_dim(WIDTH_ADDR, 7);
        write_dim(WIDTH_ADDR, 32'hFFFF_F006);
        read_dim(WIDTH_ADDR, 7);
        write_dim(WIDTH_ADDR, 32'h0000_0FFF);
        read_dim(WIDTH_ADDR, 2048);
        write_dim(WIDTH_ADDR, 32'h5A5A_A801);
        read_dim(WIDTH_ADDR, 2048);
        write_dim(HEIGHT_ADDR, 32'h0000_0003);
        read_dim(HEIGHT_ADDR, 7);
        write_dim(HEIGHT_ADDR, 32'hFFFF_FFFF);
        read_dim(HEIGHT_ADDR, 2048);
        write_dim(HEIGHT_ADDR, 32'hA5A5_5000);
        read_dim(HEIGHT_ADDR, 7);

        // Random phases over small frames. Each phase sets a size, which also
        // restarts the frame, then streams up to two frames and a row, so
        // frames wrap and restarts fall in the middle of rows. The first phase
        // is a smallest frame of full-white pixels, which drives the blurred
        // value to its top. Two phases in the middle run without any idling.
        phase = 0;
        random_start = pixels_sent;
        while (pixels_sent - random_start < RANDOM_ITEMS) begin
            calm <= (phase == 4 || phase == 5);
            if (phase == 0) begin
                texture = TEXTURE_WHITE;
                write_dim(WIDTH_ADDR, ($urandom() & 32'hFFFF_F000) | KSIZE);
                write_dim(HEIGHT_ADDR, ($urandom() & 32'hFFFF_F000) | KSIZE);
            end else begin
                texture = t_texture'($urandom_range(2));
                if ($urandom_range(3) != 0) begin
                    write_dim(WIDTH_ADDR, ($urandom() & 32'hFFFF_F000) | $urandom_range(12, 7));
                    write_dim(HEIGHT_ADDR, ($urandom() & 32'hFFFF_F000) | $urandom_range(10, 7));
                end else if ($urandom_range(1) != 0) begin
                    // Same width again: only the restart is seen.
                    write_dim(WIDTH_ADDR, frame_w);
                end else begin
                    write_dim(HEIGHT_ADDR, frame_h);
                end
            end
            if ($urandom_range(3) == 0) begin
                read_dim(WIDTH_ADDR, frame_w);
                read_dim(HEIGHT_ADDR, frame_h);
            end
            count = (phase == 0) ? 2 * frame_w * frame_h + frame_w
                                 : $urandom_range(2 * frame_w * frame_h + frame_w, 1);
            repeat (count) begin
                case (texture)
                    TEXTURE_WHITE: begin
                        b = '1;
                        g = '1;
                        r = '1;
                    end
                    TEXTURE_BINARY: begin
                        b = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                        g = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                        r = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
                    end
                    default: begin
                        b = PIX_W'($urandom());
                        g = PIX_W'($urandom());
                        r = PIX_W'($urandom());
                    end
                endcase
                send_pixel(b, g, r, 1'b0, BORDER_WORD);
            end
            drain_words();
            phase++;
        end
        calm <= 1'b0;

        // The largest sizes, each against the smallest other side: a widest
        // frame of seven rows and a tallest frame of seven columns, each run
        // for a short stretch after the restart.
        for (int k = 0; k < 2; k++) begin
            write_dim(WIDTH_ADDR, (k == 0) ? MAX_DIM : KSIZE);
            write_dim(HEIGHT_ADDR, (k == 0) ? KSIZE : MAX_DIM);
            repeat (MAX_SIZE_ITEMS) begin
                send_pixel(PIX_W'($urandom()), PIX_W'($urandom()), PIX_W'($urandom()),
                           1'b0, BORDER_WORD);
            end
            drain_words();
        end

        // Idle on to catch any stray word after the last one owed.
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("gray_box_blur_7x7 regression: pass");
        end else begin
            $display("gray_box_blur_7x7 regression: fail");
        end
        $finish;
    end

endmodule

>>> files.f
src/gbb_pkg.sv
src/gbb_apb_regs.sv
src/gbb_line_mem.sv
src/gbb_window.sv
src/gray_box_blur_7x7.sv
tb/sv/testbench.sv
